// ===== src/ald_pkg.sv =====
// shared types and codes for the auto layer dwell timer
// no dependencies; imported by ald_event_logic and auto_layer_dwell_timer
package ald_pkg;

   // default sizes
   localparam int POSITION_COUNT_DEFAULT = 128;
   localparam int LAYER_COUNT_DEFAULT    = 32;

   // width of the excluded-position bitmap held in the two csr words
   localparam int EXCL_BITS = 128;

   // event codes
   localparam logic [2:0] FUNC_TICK    = 3'd0;
   localparam logic [2:0] FUNC_MOTION  = 3'd1;
   localparam logic [2:0] FUNC_PRESS   = 3'd2;
   localparam logic [2:0] FUNC_KEYCODE = 3'd3;
   localparam logic [2:0] FUNC_REPORT  = 3'd4;

   // layer commands
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_ON   = 2'd1;
   localparam logic [1:0] CMD_OFF  = 2'd2;

   // csr register indexes
   localparam logic [2:0] CSR_TARGET_LAYER = 3'd0;
   localparam logic [2:0] CSR_DWELL_MS     = 3'd1;
   localparam logic [2:0] CSR_EXTEND_TIME  = 3'd2;
   localparam logic [2:0] CSR_QUIET_MS     = 3'd3;
   localparam logic [2:0] CSR_EXCL_LOW     = 3'd4;
   localparam logic [2:0] CSR_EXCL_HIGH    = 3'd5;

   typedef struct packed {
      logic        held_active;
      logic        layer_on_seen;
      logic [15:0] dwell_remaining;
      logic [15:0] since_key_ms;
   } ald_state_type;

   typedef struct packed {
      logic [4:0]           target_layer;
      logic [15:0]          dwell_ms;
      logic [15:0]          extend_time;
      logic [15:0]          quiet_ms;
      logic [EXCL_BITS-1:0] excluded;
   } ald_cfg_type;

   typedef struct packed {
      logic [1:0] layer_command;
      logic [4:0] command_layer;
      logic       held;
   } ald_result_type;

endpackage

// ===== src/ald_event_logic.sv =====
// per-event next state and result for the auto layer dwell timer
// depends on ald_pkg
module ald_event_logic #(
   parameter int POSITION_COUNT = ald_pkg::POSITION_COUNT_DEFAULT,
   parameter int LAYER_COUNT    = ald_pkg::LAYER_COUNT_DEFAULT
) (
   input  logic [2:0]             func,
   input  logic [6:0]             key_position,
   input  logic                   layer_is_on,
   input  ald_pkg::ald_cfg_type   cfg,
   input  ald_pkg::ald_state_type state_cur,
   output ald_pkg::ald_state_type state_nxt,
   output ald_pkg::ald_result_type result
);
   import ald_pkg::*;

   localparam logic [8:0] POS_LIMIT   = 9'(POSITION_COUNT);
   localparam logic [5:0] LAYER_LIMIT = 6'(LAYER_COUNT);

   logic       pos_excluded;
   logic       layer_valid;
   logic [1:0] cmd;

   assign pos_excluded = ({2'b00, key_position} < POS_LIMIT) && cfg.excluded[key_position];
   assign layer_valid  = {1'b0, cfg.target_layer} < LAYER_LIMIT;

   always_comb begin
      state_nxt = state_cur;
      cmd       = CMD_NONE;
      unique case (func)
         FUNC_TICK: begin
            if (state_cur.since_key_ms != 16'hFFFF) begin
               state_nxt.since_key_ms = state_cur.since_key_ms + 16'd1;
            end
            if (state_cur.dwell_remaining != 16'd0) begin
               state_nxt.dwell_remaining = state_cur.dwell_remaining - 16'd1;
               // expiry only matters while the layer is believed on
               if (state_cur.dwell_remaining == 16'd1 && state_cur.layer_on_seen) begin
                  state_nxt.held_active   = 1'b0;
                  state_nxt.layer_on_seen = 1'b0;
                  cmd                     = CMD_OFF;
               end
            end
         end
         FUNC_MOTION: begin
            if (layer_valid) begin
               if (!state_cur.held_active &&
                   state_cur.since_key_ms >= cfg.quiet_ms) begin
                  state_nxt.held_active = 1'b1;
                  if (!state_cur.layer_on_seen) begin
                     state_nxt.layer_on_seen = 1'b1;
                     cmd                     = CMD_ON;
                  end
               end
               // timer re-armed even when activation was refused
               if (cfg.dwell_ms != 16'd0) begin
                  state_nxt.dwell_remaining = cfg.dwell_ms;
               end
            end
         end
         FUNC_PRESS: begin
            if (state_cur.held_active) begin
               if (!pos_excluded) begin
                  state_nxt.held_active = 1'b0;
                  if (state_cur.layer_on_seen) begin
                     state_nxt.layer_on_seen = 1'b0;
                     cmd                     = CMD_OFF;
                  end
               end else if (cfg.extend_time != 16'd0) begin
                  state_nxt.dwell_remaining = cfg.extend_time;
               end
            end
         end
         FUNC_KEYCODE: begin
            state_nxt.since_key_ms = 16'd0;
         end
         FUNC_REPORT: begin
            state_nxt.layer_on_seen = layer_is_on;
            if (!layer_is_on) begin
               state_nxt.held_active     = 1'b0;
               state_nxt.dwell_remaining = 16'd0;
            end
         end
         default: begin
         end
      endcase
   end

   assign result.layer_command = cmd;
   assign result.command_layer = cfg.target_layer;
   assign result.held          = state_nxt.held_active;

endmodule

// ===== src/auto_layer_dwell_timer.sv =====
// top level of the auto layer dwell timer: csr bank, state, result register with skid
// depends on ald_pkg and ald_event_logic
//
//  channel   direction  handshake          payload
//  req       in         req_valid/stall    func, key_position, layer_is_on
//  rsp       out        rsp_valid/stall    layer_command, command_layer, held
//  csr       in         csr_valid/ready    index, data (write only)
//
// one transaction per cycle unless req_stall is high; each result is registered.
// the state update is one pass of ald_event_logic between the state and result registers.
// reset clears state, csr values, and the result and skid valids.
// a stalled result keeps the skid stage free for one more transaction; req_stall
// rises only while the skid stage holds a result. csr writes are always taken.
module auto_layer_dwell_timer #(
   parameter int POSITION_COUNT = ald_pkg::POSITION_COUNT_DEFAULT,
   parameter int LAYER_COUNT    = ald_pkg::LAYER_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [6:0]  req_key_position,
   input  logic        req_layer_is_on,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_layer_command,
   output logic [4:0]  rsp_command_layer,
   output logic        rsp_held,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import ald_pkg::*;

   ald_cfg_type    cfg_ff, cfg_in;
   ald_state_type  state_ff, state_in;
   ald_result_type result;
   ald_result_type out_ff, out_in;
   ald_result_type skid_ff, skid_in;
   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   logic           req_take;
   logic           rsp_take;

   ald_event_logic #(
      .POSITION_COUNT (POSITION_COUNT),
      .LAYER_COUNT    (LAYER_COUNT)
   ) u_event (
      .func         (req_func),
      .key_position (req_key_position),
      .layer_is_on  (req_layer_is_on),
      .cfg          (cfg_ff),
      .state_cur    (state_ff),
      .state_nxt    (state_in),
      .result       (result)
   );

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET_LAYER: cfg_in.target_layer     = csr_data[4:0];
            CSR_DWELL_MS:     cfg_in.dwell_ms         = csr_data[15:0];
            CSR_EXTEND_TIME:  cfg_in.extend_time      = csr_data[15:0];
            CSR_QUIET_MS:     cfg_in.quiet_ms         = csr_data[15:0];
            CSR_EXCL_LOW:     cfg_in.excluded[63:0]   = csr_data;
            CSR_EXCL_HIGH:    cfg_in.excluded[127:64] = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      priority if (skid_valid_ff) begin
         if (rsp_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff || rsp_take) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '0;
         state_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_layer_command = out_ff.layer_command;
   assign rsp_command_layer = out_ff.command_layer;
   assign rsp_held          = out_ff.held;

   // the skid stage only fills behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while the output register is empty");

   // a transaction taken while the output register is empty yields a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !out_valid_ff) |=> out_valid_ff)
      else $error("accepted transaction produced no result");

   // an on command leaves the layer held, an off command leaves it released
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_layer_command == CMD_ON) |-> rsp_held)
      else $error("on command without hold");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_layer_command == CMD_OFF) |-> !rsp_held)
      else $error("off command while still held");

endmodule
